// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the deauth flood detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define DDET_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ddet assertion failed");

// next-cycle implication, masked during reset
`define DDET_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ddet assertion failed");

// next-cycle implication, also checked while reset is high
`define DDET_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ddet assertion failed");

`endif

// File: rtl/core/ddet_pkg.sv
// ----------------------------------------------------------------------------
// ddet_pkg
// Types, constants and scaling functions shared by the deauth flood detector.
// ----------------------------------------------------------------------------
package ddet_pkg;

   // history ring
   localparam int HISTORY_DEPTH = 24;
   localparam int SLOT_W        = $clog2(HISTORY_DEPTH);

   // csr map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_WINDOW_MS        = 3'd0,
      REG_BURST_THRESHOLD  = 3'd1,
      REG_ATTACK_THRESHOLD = 3'd2,
      REG_CONFIRM_WINDOWS  = 3'd3,
      REG_STREAK_CAP       = 3'd4,
      REG_QUIET_MS         = 3'd5
   } reg_index_type;

   localparam logic [15:0] RST_WINDOW_MS        = 16'd1000;
   localparam logic [15:0] RST_BURST_THRESHOLD  = 16'd8;
   localparam logic [15:0] RST_ATTACK_THRESHOLD = 16'd25;
   localparam logic [2:0]  RST_CONFIRM_WINDOWS  = 3'd2;
   localparam logic [2:0]  RST_STREAK_CAP       = 3'd5;
   localparam logic [15:0] RST_QUIET_MS         = 16'd3000;

   typedef enum logic [1:0] {
      CMD_FRAME   = 2'd0,
      CMD_POLL    = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   // frame control subtype nibbles
   localparam logic [3:0] SUB_DISASSOC = 4'hA;
   localparam logic [3:0] SUB_DEAUTH   = 4'hC;

   // scaling constants
   localparam logic [7:0]  P_CLAMP      = 8'd250;
   localparam logic [6:0]  ACT_MAX      = 7'd100;
   localparam logic [6:0]  METER_SPAN   = 7'd110;
   localparam logic [6:0]  METER_BASE   = 7'd8;
   localparam logic [3:0]  HEIGHT_MAX   = 4'd8;
   // x/249 = (x*METER_RECIP)>>METER_SHIFT for x <= 27390
   localparam logic [16:0] METER_RECIP  = 17'd67379;
   localparam int          METER_SHIFT  = 24;
   // x/250 = (x*HEIGHT_RECIP)>>HEIGHT_SHIFT for x <= 1992
   localparam logic [12:0] HEIGHT_RECIP = 13'd4195;
   localparam int          HEIGHT_SHIFT = 20;

   typedef struct packed {
      logic [15:0] window_ms;
      logic [15:0] burst_threshold;
      logic [15:0] attack_threshold;
      logic [2:0]  confirm_windows;
      logic [2:0]  streak_cap;
      logic [15:0] quiet_ms;
   } cfg_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] timestamp_ms;
      logic        frame_is_mgmt;
      logic [7:0]  frame_control;
   } item_type;

   typedef struct packed {
      logic [31:0] window_packets;
      logic [31:0] window_suspicious;
      logic [31:0] total_packets;
      logic [31:0] total_suspicious;
      logic        attack_alert;
      logic [2:0]  burst_streak;
      logic [6:0]  meter_width;
      logic [3:0]  history_height;
      logic [4:0]  history_slot;
      logic [6:0]  activity_level;
      logic [3:0]  last_alarm_subtype;
   } result_type;

   // 0 when idle, else (min(p,250)-1)*110/249+8
   function automatic logic [6:0] meter_calc(input logic [31:0] p);
      logic [7:0]  c;
      logic [14:0] x;
      logic [31:0] prod;
      logic [6:0]  q;
      c    = (p > 32'(P_CLAMP)) ? P_CLAMP : p[7:0];
      x    = 15'(c - 8'd1) * 15'(METER_SPAN);
      prod = 32'(x) * 32'(METER_RECIP);
      q    = prod[METER_SHIFT +: 7];
      return (p == 32'd0) ? 7'd0 : (q + METER_BASE);
   endfunction

   // min(p*8/250, 8)
   function automatic logic [3:0] height_calc(input logic [31:0] p);
      logic [10:0] p8;
      logic [23:0] prod;
      p8   = {p[7:0], 3'b000};
      prod = 24'(p8) * 24'(HEIGHT_RECIP);
      return (p >= 32'(P_CLAMP)) ? HEIGHT_MAX : prod[HEIGHT_SHIFT +: 4];
   endfunction

   function automatic logic [6:0] activity_calc(input logic [31:0] p);
      return (p > 32'(ACT_MAX)) ? ACT_MAX : p[6:0];
   endfunction

endpackage

// File: rtl/core/ddet_in_stage.sv
// ----------------------------------------------------------------------------
// ddet_in_stage
// Input register; holds one word until the update logic takes it.
// ----------------------------------------------------------------------------
module ddet_in_stage
   import ddet_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_timestamp_ms,
   input  logic        req_frame_is_mgmt,
   input  logic [7:0]  req_frame_control,
   input  logic        advance,
   output logic        item_valid,
   output item_type    item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;

   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign valid_in  = accept | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.cmd           <= cmd_type'(req_cmd);
         item_ff.timestamp_ms  <= req_timestamp_ms;
         item_ff.frame_is_mgmt <= req_frame_is_mgmt;
         item_ff.frame_control <= req_frame_control;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/core/ddet_csr.sv
// ----------------------------------------------------------------------------
// ddet_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module ddet_csr
   import ddet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms        <= RST_WINDOW_MS;
         cfg_ff.burst_threshold  <= RST_BURST_THRESHOLD;
         cfg_ff.attack_threshold <= RST_ATTACK_THRESHOLD;
         cfg_ff.confirm_windows  <= RST_CONFIRM_WINDOWS;
         cfg_ff.streak_cap       <= RST_STREAK_CAP;
         cfg_ff.quiet_ms         <= RST_QUIET_MS;
      end else if (wr_en) begin
         case (idx)
            REG_WINDOW_MS:        cfg_ff.window_ms        <= csr_pwdata[15:0];
            REG_BURST_THRESHOLD:  cfg_ff.burst_threshold  <= csr_pwdata[15:0];
            REG_ATTACK_THRESHOLD: cfg_ff.attack_threshold <= csr_pwdata[15:0];
            REG_CONFIRM_WINDOWS:  cfg_ff.confirm_windows  <= csr_pwdata[2:0];
            REG_STREAK_CAP:       cfg_ff.streak_cap       <= csr_pwdata[2:0];
            REG_QUIET_MS:         cfg_ff.quiet_ms         <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_WINDOW_MS:        csr_prdata = 32'(cfg_ff.window_ms);
         REG_BURST_THRESHOLD:  csr_prdata = 32'(cfg_ff.burst_threshold);
         REG_ATTACK_THRESHOLD: csr_prdata = 32'(cfg_ff.attack_threshold);
         REG_CONFIRM_WINDOWS:  csr_prdata = 32'(cfg_ff.confirm_windows);
         REG_STREAK_CAP:       csr_prdata = 32'(cfg_ff.streak_cap);
         REG_QUIET_MS:         csr_prdata = 32'(cfg_ff.quiet_ms);
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/ddet_core.sv
// ----------------------------------------------------------------------------
// ddet_core
// Monitor state and its update logic for frame, poll and restart.
// ----------------------------------------------------------------------------
module ddet_core
   import ddet_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       item_valid,
   input  item_type   item,
   input  logic       out_free,
   output logic       advance,
   output logic       fire,
   output result_type result
);

   logic [31:0]       win_frames_ff, win_frames_in;
   logic [31:0]       win_suspect_ff, win_suspect_in;
   logic [31:0]       all_frames_ff, all_frames_in;
   logic [31:0]       all_suspect_ff, all_suspect_in;
   logic [31:0]       window_start_ff, window_start_in;
   logic [31:0]       last_suspect_time_ff, last_suspect_time_in;
   logic [2:0]        streak_ff, streak_in;
   logic              alarm_ff, alarm_in;
   logic [SLOT_W-1:0] slot_index_ff, slot_index_in;
   logic [3:0]        suspect_kind_ff, suspect_kind_in;

   logic [31:0]       elapsed, quiet_elapsed;
   logic              closes, take;
   logic [3:0]        sub;
   logic              is_suspect;
   logic [2:0]        streak_step;
   logic              alarm_set, alarm_clr;
   logic [SLOT_W+4:0] slot_wide;

   assign elapsed       = item.timestamp_ms - window_start_ff;
   assign quiet_elapsed = item.timestamp_ms - last_suspect_time_ff;
   assign closes  = item_valid && (item.cmd == CMD_POLL) && (elapsed > 32'(cfg.window_ms));
   assign advance = ~closes | out_free;
   assign take    = item_valid & advance;
   assign fire    = take & closes;

   assign sub        = item.frame_control[7:4];
   assign is_suspect = (sub == SUB_DISASSOC) || (sub == SUB_DEAUTH);

   // streak after the burst test
   always_comb begin
      streak_step = streak_ff;
      if (win_suspect_ff >= 32'(cfg.burst_threshold)) begin
         if (streak_ff < cfg.streak_cap) streak_step = streak_ff + 3'd1;
      end else if (streak_ff != 3'd0) begin
         streak_step = streak_ff - 3'd1;
      end
   end

   assign alarm_set = (win_suspect_ff >= 32'(cfg.attack_threshold)) ||
                      (streak_step >= cfg.confirm_windows);
   assign alarm_clr = ~alarm_set && (win_suspect_ff == 32'd0) &&
                      (quiet_elapsed > 32'(cfg.quiet_ms));

   always_comb begin
      win_frames_in        = win_frames_ff;
      win_suspect_in       = win_suspect_ff;
      all_frames_in        = all_frames_ff;
      all_suspect_in       = all_suspect_ff;
      window_start_in      = window_start_ff;
      last_suspect_time_in = last_suspect_time_ff;
      streak_in            = streak_ff;
      alarm_in             = alarm_ff;
      slot_index_in        = slot_index_ff;
      suspect_kind_in      = suspect_kind_ff;
      if (take) begin
         case (item.cmd)
            CMD_FRAME: begin
               if (item.frame_is_mgmt) begin
                  win_frames_in = win_frames_ff + 32'd1;
                  all_frames_in = all_frames_ff + 32'd1;
                  if (is_suspect) begin
                     win_suspect_in       = win_suspect_ff + 32'd1;
                     all_suspect_in       = all_suspect_ff + 32'd1;
                     last_suspect_time_in = item.timestamp_ms;
                     suspect_kind_in      = sub;
                  end
               end
            end
            CMD_POLL: begin
               if (closes) begin
                  streak_in       = alarm_clr ? 3'd0 : streak_step;
                  alarm_in        = alarm_set ? 1'b1 : (alarm_clr ? 1'b0 : alarm_ff);
                  win_frames_in   = '0;
                  win_suspect_in  = '0;
                  window_start_in = item.timestamp_ms;
                  slot_index_in   = (slot_index_ff == SLOT_W'(HISTORY_DEPTH - 1)) ?
                                    '0 : slot_index_ff + SLOT_W'(1);
               end
            end
            CMD_RESTART: begin
               win_frames_in        = '0;
               win_suspect_in       = '0;
               all_frames_in        = '0;
               all_suspect_in       = '0;
               window_start_in      = item.timestamp_ms;
               last_suspect_time_in = '0;
               streak_in            = '0;
               alarm_in             = 1'b0;
               slot_index_in        = '0;
               suspect_kind_in      = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_frames_ff        <= '0;
         win_suspect_ff       <= '0;
         all_frames_ff        <= '0;
         all_suspect_ff       <= '0;
         window_start_ff      <= '0;
         last_suspect_time_ff <= '0;
         streak_ff            <= '0;
         alarm_ff             <= 1'b0;
         slot_index_ff        <= '0;
         suspect_kind_ff      <= '0;
      end else begin
         win_frames_ff        <= win_frames_in;
         win_suspect_ff       <= win_suspect_in;
         all_frames_ff        <= all_frames_in;
         all_suspect_ff       <= all_suspect_in;
         window_start_ff      <= window_start_in;
         last_suspect_time_ff <= last_suspect_time_in;
         streak_ff            <= streak_in;
         alarm_ff             <= alarm_in;
         slot_index_ff        <= slot_index_in;
         suspect_kind_ff      <= suspect_kind_in;
      end
   end

   // history slot carries the low five bits of the ring index
   assign slot_wide = (SLOT_W + 5)'(slot_index_ff);

   always_comb begin
      result.window_packets     = win_frames_ff;
      result.window_suspicious  = win_suspect_ff;
      result.total_packets      = all_frames_ff;
      result.total_suspicious   = all_suspect_ff;
      result.attack_alert       = alarm_in;
      result.burst_streak       = streak_in;
      result.meter_width        = meter_calc(win_frames_ff);
      result.history_height     = height_calc(win_frames_ff);
      result.history_slot       = slot_wide[4:0];
      result.activity_level     = activity_calc(win_frames_ff);
      result.last_alarm_subtype = suspect_kind_ff;
   end

endmodule

// File: rtl/core/ddet_out_stage.sv
// ----------------------------------------------------------------------------
// ddet_out_stage
// Result register; holds a word while the consumer stalls.
// ----------------------------------------------------------------------------
module ddet_out_stage
   import ddet_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  result_type result,
   output logic       out_free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_word
);

   logic       valid_ff, valid_in;
   result_type word_ff;

   assign out_free = ~valid_ff | ~rsp_stall;
   assign valid_in = fire | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// File: rtl/core/deauth_flood_detector.sv
// ----------------------------------------------------------------------------
// deauth_flood_detector
// Counts management frames and disassoc/deauth frames per time window and
// raises an alarm on a flood of them.
// ----------------------------------------------------------------------------
// Usage: one word per clock while req_stall is low. A word is registered at
// the input; from there the whole update (counters, window close, streak,
// alarm, scaled display values) runs, and a closing poll writes its result
// to the result register that drives rsp_. Frames, restarts and polls that
// leave the window open produce no result word. req_stall only rises while
// a closing poll sits in the input register and the result register is full
// and stalled. Configuration must be written only while the block is idle;
// the block does not enforce it. All registers read back at their own width.
// ----------------------------------------------------------------------------
module deauth_flood_detector
   import ddet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input words
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  logic [31:0]           req_timestamp_ms,
   input  logic                  req_frame_is_mgmt,
   input  logic [7:0]            req_frame_control,
   // result words
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_window_packets,
   output logic [31:0]           rsp_window_suspicious,
   output logic [31:0]           rsp_total_packets,
   output logic [31:0]           rsp_total_suspicious,
   output logic                  rsp_attack_alert,
   output logic [2:0]            rsp_burst_streak,
   output logic [6:0]            rsp_meter_width,
   output logic [3:0]            rsp_history_height,
   output logic [4:0]            rsp_history_slot,
   output logic [6:0]            rsp_activity_level,
   output logic [3:0]            rsp_last_alarm_subtype,
   // config
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   item_type   item;
   result_type result, rsp_word;
   logic       item_valid, advance, fire, out_free;

   ddet_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register
   ddet_in_stage u_in (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_timestamp_ms  (req_timestamp_ms),
      .req_frame_is_mgmt (req_frame_is_mgmt),
      .req_frame_control (req_frame_control),
      .advance           (advance),
      .item_valid        (item_valid),
      .item              (item)
   );

   // state update; holds a closing poll only when the result slot is busy
   ddet_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .advance    (advance),
      .fire       (fire),
      .result     (result)
   );

   // result register
   ddet_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_window_packets     = rsp_word.window_packets;
   assign rsp_window_suspicious  = rsp_word.window_suspicious;
   assign rsp_total_packets      = rsp_word.total_packets;
   assign rsp_total_suspicious   = rsp_word.total_suspicious;
   assign rsp_attack_alert       = rsp_word.attack_alert;
   assign rsp_burst_streak       = rsp_word.burst_streak;
   assign rsp_meter_width        = rsp_word.meter_width;
   assign rsp_history_height     = rsp_word.history_height;
   assign rsp_history_slot       = rsp_word.history_slot;
   assign rsp_activity_level     = rsp_word.activity_level;
   assign rsp_last_alarm_subtype = rsp_word.last_alarm_subtype;

endmodule

// File: rtl/core/ddet_checker.sv
// ----------------------------------------------------------------------------
// ddet_checker
// Port-level checks on the deauth flood detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddet_checker
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_window_packets,
   input logic [31:0] rsp_total_packets,
   input logic [6:0]  rsp_meter_width,
   input logic [3:0]  rsp_history_height,
   input logic [4:0]  rsp_history_slot,
   input logic [6:0]  rsp_activity_level
);

   // a stalled result word holds
   `DDET_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_window_packets) && $stable(rsp_total_packets) && $stable(rsp_history_slot))

   // reset empties both registers
   `DDET_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

   // an empty window scales to zero everywhere
   `DDET_ASSERT_IMPLY(a_idle_scale, clock, reset, rsp_valid && rsp_window_packets == 32'd0, rsp_meter_width == 7'd0 && rsp_history_height == 4'd0 && rsp_activity_level == 7'd0)

   // a full window saturates meter, bar and activity
   `DDET_ASSERT_IMPLY(a_full_scale, clock, reset, rsp_valid && rsp_window_packets >= 32'd250, rsp_meter_width == 7'd118 && rsp_history_height == 4'd8 && rsp_activity_level == 7'd100)

endmodule

bind deauth_flood_detector ddet_checker u_ddet_checker (.*);
